/* sv/ray_sphere_intersect_top_macros.svh */
// ---------------------------------------------------------------------------
// ray sphere intersect assertion macros
// concurrent check wrappers, empty under synthesis
// ---------------------------------------------------------------------------
`ifndef RAY_SPHERE_INTERSECT_TOP_MACROS_SVH
`define RAY_SPHERE_INTERSECT_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define RSI_ASSERT_IMPLY(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
`define RSI_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`else
`define RSI_ASSERT_IMPLY(label, clk, rst, a, b)
`define RSI_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

/* sv/rsi_pkg.sv */
// ---------------------------------------------------------------------------
// rsi_pkg
// shared widths, register indexes and stage types
// ---------------------------------------------------------------------------
package rsi_pkg;
   localparam int FRAC_BITS_DEF = 16;
   localparam int POS_W  = 32;
   localparam int RAD_W  = 31;
   localparam int L_W    = 33;
   localparam int TCA_W  = 36;
   localparam int DISC_W = 74;
   localparam int ROOT_W = DISC_W / 2;
   localparam int REM_W  = ROOT_W + 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Z = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS   = 2'd3;

   typedef struct packed {
      logic              valid;
      logic              miss;
      logic [TCA_W-1:0]  tca;
      logic [DISC_W-1:0] disc;
   } front_out_type;

   typedef struct packed {
      logic              valid;
      logic              miss;
      logic [TCA_W-1:0]  tca;
      logic [ROOT_W-1:0] root;
   } sqrt_out_type;

   typedef struct packed {
      logic              valid;
      logic              miss;
      logic [TCA_W-1:0]  tca;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
      logic [DISC_W-1:0] rest;
   } sq_stage_type;
endpackage

/* sv/rsi_front.sv */
// ---------------------------------------------------------------------------
// rsi_front
// vector to center, projection and discriminant, seven register stages
// ---------------------------------------------------------------------------
module rsi_front #(
   parameter int FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  logic signed [rsi_pkg::POS_W-1:0] origin_x,
   input  logic signed [rsi_pkg::POS_W-1:0] origin_y,
   input  logic signed [rsi_pkg::POS_W-1:0] origin_z,
   input  logic signed [FRAC_BITS+1:0]      dir_x,
   input  logic signed [FRAC_BITS+1:0]      dir_y,
   input  logic signed [FRAC_BITS+1:0]      dir_z,
   input  logic signed [rsi_pkg::POS_W-1:0] center_x,
   input  logic signed [rsi_pkg::POS_W-1:0] center_y,
   input  logic signed [rsi_pkg::POS_W-1:0] center_z,
   input  logic        [rsi_pkg::RAD_W-1:0] radius,
   output rsi_pkg::front_out_type           out
);
   import rsi_pkg::*;

   localparam int DIR_W = FRAC_BITS + 2;
   localparam int PRD_W = L_W + DIR_W;
   localparam int DOT_W = PRD_W + 2;
   localparam int SQ_W  = 64;
   localparam int LS_W  = SQ_W + 2;
   localparam int R2_W  = 2 * RAD_W;
   localparam int HALF  = TCA_W / 2;

   // stage 1
   logic [5:0] vld_ff;
   logic signed [L_W-1:0]   lx_ff, ly_ff, lz_ff;
   logic signed [DIR_W-1:0] dx_ff, dy_ff, dz_ff;
   // stage 2
   logic signed [PRD_W-1:0] px_ff, py_ff, pz_ff;
   logic [SQ_W-1:0]         sx_ff, sy_ff, sz_ff;
   logic [R2_W-1:0]         r2_2_ff;
   // stage 3
   logic signed [DOT_W-1:0] dot_ff;
   logic [LS_W-1:0]         ls3_ff;
   logic [R2_W-1:0]         r2_3_ff;
   // stage 4
   logic [TCA_W-1:0]        tca4_ff;
   logic                    miss4_ff;
   logic [LS_W-1:0]         ls4_ff;
   logic [R2_W-1:0]         r2_4_ff;
   // stage 5
   logic [TCA_W-1:0]        tca5_ff;
   logic                    miss5_ff;
   logic [LS_W-1:0]         ls5_ff;
   logic [R2_W-1:0]         r2_5_ff;
   logic [2*HALF-1:0]       aa_ff, ab_ff, bb_ff;
   // stage 6
   logic [TCA_W-1:0]        tca6_ff;
   logic                    miss6_ff;
   logic [LS_W-1:0]         ls6_ff;
   logic [DISC_W-1:0]       pos6_ff;
   // stage 7
   front_out_type           out_ff;

   logic signed [2*L_W-1:0] sqx, sqy, sqz;
   logic [DISC_W-1:0]       pos_in;
   logic [DISC_W-1:0]       ls_ext;
   logic                    dot_pos;

   assign sqx = lx_ff * lx_ff;
   assign sqy = ly_ff * ly_ff;
   assign sqz = lz_ff * lz_ff;
   assign dot_pos = !dot_ff[DOT_W-1] && (|dot_ff);

   // tca squared rebuilt from half products
   assign pos_in = DISC_W'(r2_5_ff)
                 + ({{(DISC_W-2*HALF){1'b0}}, aa_ff} << (2*HALF))
                 + ({{(DISC_W-2*HALF){1'b0}}, ab_ff} << (HALF+1))
                 + DISC_W'(bb_ff);
   assign ls_ext = DISC_W'(ls6_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         out_ff.valid <= 1'b0;
      end else if (en) begin
         vld_ff <= {vld_ff[4:0], in_valid};
         out_ff.valid <= vld_ff[5];
      end
      if (en) begin
         lx_ff <= L_W'(center_x) - L_W'(origin_x);
         ly_ff <= L_W'(center_y) - L_W'(origin_y);
         lz_ff <= L_W'(center_z) - L_W'(origin_z);
         dx_ff <= dir_x;
         dy_ff <= dir_y;
         dz_ff <= dir_z;

         px_ff <= PRD_W'(lx_ff * dx_ff);
         py_ff <= PRD_W'(ly_ff * dy_ff);
         pz_ff <= PRD_W'(lz_ff * dz_ff);
         sx_ff <= sqx[SQ_W-1:0];
         sy_ff <= sqy[SQ_W-1:0];
         sz_ff <= sqz[SQ_W-1:0];
         r2_2_ff <= radius * radius;

         dot_ff  <= DOT_W'(px_ff) + DOT_W'(py_ff) + DOT_W'(pz_ff);
         ls3_ff  <= LS_W'(sx_ff) + LS_W'(sy_ff) + LS_W'(sz_ff);
         r2_3_ff <= r2_2_ff;

         tca4_ff  <= dot_ff[FRAC_BITS+TCA_W-1:FRAC_BITS];
         miss4_ff <= !dot_pos;
         ls4_ff   <= ls3_ff;
         r2_4_ff  <= r2_3_ff;

         aa_ff    <= tca4_ff[TCA_W-1:HALF] * tca4_ff[TCA_W-1:HALF];
         ab_ff    <= tca4_ff[TCA_W-1:HALF] * tca4_ff[HALF-1:0];
         bb_ff    <= tca4_ff[HALF-1:0] * tca4_ff[HALF-1:0];
         tca5_ff  <= tca4_ff;
         miss5_ff <= miss4_ff;
         ls5_ff   <= ls4_ff;
         r2_5_ff  <= r2_4_ff;

         pos6_ff  <= pos_in;
         tca6_ff  <= tca5_ff;
         miss6_ff <= miss5_ff;
         ls6_ff   <= ls5_ff;

         // tangent or outside counts as a miss
         out_ff.miss <= miss6_ff || (pos6_ff <= ls_ext);
         out_ff.tca  <= tca6_ff;
         out_ff.disc <= pos6_ff - ls_ext;
      end
   end

   assign out = out_ff;
endmodule

/* sv/rsi_sqrt.sv */
// ---------------------------------------------------------------------------
// rsi_sqrt
// integer square root, one result bit per pipeline stage
// ---------------------------------------------------------------------------
module rsi_sqrt (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  rsi_pkg::front_out_type in,
   output rsi_pkg::sqrt_out_type  out
);
   import rsi_pkg::*;

   sq_stage_type st_ff [ROOT_W];

   genvar k;
   generate
      for (k = 0; k < ROOT_W; k++) begin : g_stage
         sq_stage_type cur;
         logic [REM_W-1:0] nxt, trial;
         if (k == 0) begin : g_first
            always_comb begin
               cur.valid = in.valid;
               cur.miss  = in.miss;
               cur.tca   = in.tca;
               cur.rem   = '0;
               cur.root  = '0;
               cur.rest  = in.disc;
            end
         end else begin : g_next
            assign cur = st_ff[k-1];
         end
         assign nxt   = {cur.rem[REM_W-3:0], cur.rest[DISC_W-1:DISC_W-2]};
         assign trial = {1'b0, cur.root, 2'b01};
         always_ff @(posedge clock) begin
            if (reset) begin
               st_ff[k].valid <= 1'b0;
            end else if (en) begin
               st_ff[k].valid <= cur.valid;
            end
            if (en) begin
               st_ff[k].miss <= cur.miss;
               st_ff[k].tca  <= cur.tca;
               st_ff[k].rest <= {cur.rest[DISC_W-3:0], 2'b00};
               if (nxt >= trial) begin
                  st_ff[k].rem  <= nxt - trial;
                  st_ff[k].root <= {cur.root[ROOT_W-2:0], 1'b1};
               end else begin
                  st_ff[k].rem  <= nxt;
                  st_ff[k].root <= {cur.root[ROOT_W-2:0], 1'b0};
               end
            end
         end
      end
   endgenerate

   assign out.valid = st_ff[ROOT_W-1].valid;
   assign out.miss  = st_ff[ROOT_W-1].miss;
   assign out.tca   = st_ff[ROOT_W-1].tca;
   assign out.root  = st_ff[ROOT_W-1].root;
endmodule

/* sv/ray_sphere_intersect_top.sv */
// ---------------------------------------------------------------------------
// ray_sphere_intersect_top
// tests one ray per item against a configured sphere, returns near hit distance
// ---------------------------------------------------------------------------
// path: an accepted item passes the front stages, then the root stages, then the output register
// throughput: one item per cycle; the whole pipe freezes while a result is stalled
// the root unit resolves one result bit per stage, which sets the depth
// reset: synchronous, clears all valid bits, center to 0 and radius to 1.0
`include "ray_sphere_intersect_top_macros.svh"
module ray_sphere_intersect_top #(
   parameter int FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // ray items
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [rsi_pkg::POS_W-1:0]      req_origin_x,
   input  logic signed [rsi_pkg::POS_W-1:0]      req_origin_y,
   input  logic signed [rsi_pkg::POS_W-1:0]      req_origin_z,
   input  logic signed [FRAC_BITS+1:0]           req_dir_x,
   input  logic signed [FRAC_BITS+1:0]           req_dir_y,
   input  logic signed [FRAC_BITS+1:0]           req_dir_z,
   // result items
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_hit,
   output logic signed [rsi_pkg::POS_W-1:0]      rsp_hit_distance,
   // register writes
   input  logic                                  csr_we,
   input  logic [rsi_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [rsi_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import rsi_pkg::*;

   localparam int DIST_W = ROOT_W + 1;
   localparam logic signed [DIST_W-1:0] SAT_MAX = DIST_W'(32'sh7fffffff);
   localparam logic signed [DIST_W-1:0] SAT_MIN = -(DIST_W'(32'sh7fffffff)) - 1;

   // sphere registers
   logic signed [POS_W-1:0] center_x_ff, center_y_ff, center_z_ff;
   logic [RAD_W-1:0]        radius_ff;

   // output register
   logic                    rsp_valid_ff;
   logic                    rsp_hit_ff;
   logic signed [POS_W-1:0] rsp_dist_ff;

   logic                    en;
   front_out_type           front;
   sqrt_out_type            root;
   logic signed [DIST_W-1:0] near_dist;

   // the pipe moves unless a finished result is waiting on the output
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         center_z_ff <= '0;
         radius_ff   <= RAD_W'(1 << FRAC_BITS_DEF);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CENTER_X: center_x_ff <= csr_wdata;
            CSR_CENTER_Y: center_y_ff <= csr_wdata;
            CSR_CENTER_Z: center_z_ff <= csr_wdata;
            CSR_RADIUS:   radius_ff   <= csr_wdata[RAD_W-1:0];
            default: ;
         endcase
      end
   end

   rsi_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .origin_x (req_origin_x),
      .origin_y (req_origin_y),
      .origin_z (req_origin_z),
      .dir_x    (req_dir_x),
      .dir_y    (req_dir_y),
      .dir_z    (req_dir_z),
      .center_x (center_x_ff),
      .center_y (center_y_ff),
      .center_z (center_z_ff),
      .radius   (radius_ff),
      .out      (front)
   );

   rsi_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .in    (front),
      .out   (root)
   );

   // near distance, both terms non-negative so one extra sign bit covers it
   assign near_dist = $signed({2'b00, root.tca}) - $signed({1'b0, root.root});

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= root.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_hit_ff <= !root.miss;
         priority if (root.miss) begin
            rsp_dist_ff <= '0;
         end else if (near_dist > SAT_MAX) begin
            rsp_dist_ff <= 32'sh7fffffff;
         end else if (near_dist < SAT_MIN) begin
            rsp_dist_ff <= 32'sh80000000;
         end else begin
            rsp_dist_ff <= near_dist[POS_W-1:0];
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_hit_distance = rsp_dist_ff;

   // a miss always reports zero distance
   `RSI_ASSERT_IMPLY(a_miss_zero, clock, reset, rsp_valid && !rsp_hit, rsp_hit_distance == 0)
   // an item that passes the discriminant test has a positive discriminant
   `RSI_ASSERT_IMPLY(a_disc_pos, clock, reset, front.valid && !front.miss, front.disc != 0)
   // a finished hit leaves the root unit and lands on the output with its flag
   `RSI_ASSERT_NEXT(a_hit_flow, clock, reset, en && root.valid && !root.miss, rsp_valid && rsp_hit)
endmodule
